### hdl/bcpc_pkg.sv
// Shared types and constants for the byte chain packet cipher.
`timescale 1ns / 1ps
`default_nettype none

package bcpc_pkg;

	// Default buffer capacity in bytes (valid range 1 to 64).
	localparam int MAX_PACKET_DEF = 64;

	// Width of the byte count and of the position count.
	localparam int CNT_W = 7;

	localparam logic [7:0] ADD_KEY = 8'h48;
	localparam logic [7:0] XOR_KEY = 8'h13;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last;
	} in_word_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_last;
		logic       overflow;
	} out_word_t;

	// Controls for one byte of a cipher pass.
	typedef struct packed {
		logic [CNT_W-1:0] pos;
		logic             backward;
		logic             decode;
		logic             first;
	} xf_ctrl_t;

endpackage

`default_nettype wire

### hdl/bcpc_mem.sv
// Packet buffer memory: one write port and one read port with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module bcpc_mem #(
	parameter int DEPTH = bcpc_pkg::MAX_PACKET_DEF,
	parameter int AW    = 6
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [7:0]    wdata,
	input  wire logic          ren,
	input  wire logic [AW-1:0] raddr,
	output logic      [7:0]    rdata
);

	logic [7:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read returns the old contents when the same entry is written in the same cycle.
	always_ff @(posedge clk) begin
		if (ren) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

### hdl/bcpc_xform.sv
// Byte transform for one step of a forward or backward pass, encode or decode.
`timescale 1ns / 1ps
`default_nettype none

module bcpc_xform (
	input  wire bcpc_pkg::xf_ctrl_t ctrl,
	input  wire logic [7:0]         din,
	input  wire logic [7:0]         chain,
	output logic      [7:0]         dout,
	output logic      [7:0]         chain_nx
);

	function automatic logic [7:0] rol8(input logic [7:0] v, input logic [2:0] n);
		logic [15:0] d;
		d = {v, v} << n;
		return d[15:8];
	endfunction

	function automatic logic [7:0] ror8(input logic [7:0] v, input logic [2:0] n);
		logic [15:0] d;
		d = {v, v} >> n;
		return d[7:0];
	endfunction

	logic [7:0] pos8;
	logic [7:0] ch;
	logic [7:0] t;
	logic [7:0] u;

	assign pos8 = 8'(ctrl.pos);
	assign ch   = ctrl.first ? 8'h00 : chain;

	always_comb begin
		t        = 8'h00;
		u        = 8'h00;
		dout     = 8'h00;
		chain_nx = 8'h00;
		if (!ctrl.decode && !ctrl.backward) begin
			t        = (rol8(din, 3'd3) + pos8) ^ ch;
			chain_nx = t;
			u        = ~ror8(t, ctrl.pos[2:0]);
			dout     = u + bcpc_pkg::ADD_KEY;
		end else if (!ctrl.decode) begin
			t        = (rol8(din, 3'd4) + pos8) ^ ch;
			chain_nx = t;
			dout     = ror8(t ^ bcpc_pkg::XOR_KEY, 3'd3);
		end else if (ctrl.backward) begin
			t        = rol8(din, 3'd3) ^ bcpc_pkg::XOR_KEY;
			chain_nx = t;
			u        = (t ^ ch) - pos8;
			dout     = ror8(u, 3'd4);
		end else begin
			u        = din - bcpc_pkg::ADD_KEY;
			t        = rol8(~u, ctrl.pos[2:0]);
			chain_nx = t;
			u        = (t ^ ch) - pos8;
			dout     = ror8(u, 3'd3);
		end
	end

endmodule

`default_nettype wire

### hdl/byte_chain_packet_cipher_core.sv
// Top level of the byte chain packet cipher: sequencer, buffer memory and byte transform.
`timescale 1ns / 1ps
`default_nettype none

// Usage. Packet bytes enter on item (data_byte, last) and are taken at a clock edge where
// start is high and busy is low; one word per cycle is allowed while busy stays low.
// Bytes are stored in order; once MAX_PACKET bytes are held, further bytes are dropped
// and the packet is flagged as overflowed. A word with last set ends the packet.
// The block then raises busy and runs three rounds over the buffer, each round being
// two passes, one byte per cycle, through the single read port of the buffer memory.
// It then reads the buffer out in order, one byte per cycle, and each result word
// sits on result for exactly one cycle, marked by strobe, with out_last on the final
// byte and overflow on every byte of a flagged packet. The last result is shown in
// the first cycle after busy falls, while a new packet may already be loading.
// The receiver cannot stall, so results are never held back.
// direction is to be written through direction_we and direction_wdata while the block is
// idle; the block does not enforce this. It is sampled when the last word of a packet
// arrives (0 encodes, 1 decodes). Reset clears all control state and selects encode;
// the buffer needs no clearing, as only entries written for the current packet are read.
module byte_chain_packet_cipher_core #(
	parameter int MAX_PACKET = bcpc_pkg::MAX_PACKET_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  wire bcpc_pkg::in_word_t  item,
	output logic                     strobe,
	output bcpc_pkg::out_word_t      result,
	input  wire logic                direction_we,
	input  wire logic                direction_wdata
);

	localparam int AW = (MAX_PACKET > 1) ? $clog2(MAX_PACKET) : 1;
	localparam int CW = bcpc_pkg::CNT_W;
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_PACKET);

	localparam logic [1:0] ST_LOAD   = 2'd0;
	localparam logic [1:0] ST_CIPHER = 2'd1;
	localparam logic [1:0] ST_EMIT   = 2'd2;

	// Control state.
	logic [1:0]    state_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] len_q;
	logic [CW-1:0] pos_q;
	logic [1:0]    round_q;
	logic          half_q;
	logic          ovf_q;
	logic          dir_q;
	logic          dec_q;
	logic          val_s1;
	logic          emit_s1;

	// Payload of the read stage.
	logic [7:0]          chain_q;
	logic [AW-1:0]       idx_s1;
	bcpc_pkg::xf_ctrl_t  xc_s1;
	logic                fwd_s1;
	logic [7:0]          fwdd_s1;
	logic                last_s1;
	logic                ovf_s1;

	logic          accept;
	logic          room;
	logic [CW-1:0] new_len;
	logic          backward;
	logic          issue;
	logic [AW-1:0] raddr;
	logic          we;
	logic [AW-1:0] waddr;
	logic [7:0]    wdata;
	logic [7:0]    rdata;
	logic [7:0]    data_s1;
	logic [7:0]    xf_out;
	logic [7:0]    chain_nx;

	assign busy     = (state_q != ST_LOAD);
	assign accept   = start && !busy;
	assign room     = (count_q < MAX_CNT);
	assign new_len  = room ? (count_q + CW'(1)) : count_q;
	assign backward = half_q ^ dec_q;
	assign issue    = (state_q == ST_CIPHER) || (state_q == ST_EMIT);

	// Forward passes walk the buffer from the front, backward passes from the end.
	always_comb begin
		if ((state_q == ST_CIPHER) && backward) begin
			raddr = AW'(pos_q - CW'(1));
		end else begin
			raddr = AW'(len_q - pos_q);
		end
	end

	// The write port serves loading while idle and the transform write-back otherwise.
	always_comb begin
		if (state_q == ST_LOAD) begin
			we    = accept && room;
			waddr = AW'(count_q);
			wdata = item.data_byte;
		end else begin
			we    = val_s1;
			waddr = idx_s1;
			wdata = xf_out;
		end
	end

	// A new pass starts on the entry the previous pass just finished, so that
	// write is forwarded to the read that is issued in the same cycle.
	assign data_s1 = fwd_s1 ? fwdd_s1 : rdata;

	bcpc_mem #(
		.DEPTH(MAX_PACKET),
		.AW   (AW)
	) u_mem (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.ren  (issue),
		.raddr(raddr),
		.rdata(rdata)
	);

	bcpc_xform u_xform (
		.ctrl    (xc_s1),
		.din     (data_s1),
		.chain   (chain_q),
		.dout    (xf_out),
		.chain_nx(chain_nx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			count_q <= '0;
			len_q   <= '0;
			pos_q   <= '0;
			round_q <= '0;
			half_q  <= 1'b0;
			ovf_q   <= 1'b0;
			dir_q   <= 1'b0;
			dec_q   <= 1'b0;
			val_s1  <= 1'b0;
			emit_s1 <= 1'b0;
			chain_q <= '0;
		end else begin
			if (direction_we) begin
				dir_q <= direction_wdata;
			end
			if (val_s1) begin
				chain_q <= chain_nx;
			end
			val_s1  <= (state_q == ST_CIPHER);
			emit_s1 <= (state_q == ST_EMIT);
			unique case (state_q)
				ST_LOAD: begin
					if (accept) begin
						if (!room) begin
							ovf_q <= 1'b1;
						end
						if (item.last) begin
							state_q <= ST_CIPHER;
							len_q   <= new_len;
							pos_q   <= new_len;
							count_q <= '0;
							round_q <= '0;
							half_q  <= 1'b0;
							dec_q   <= dir_q;
						end else begin
							count_q <= new_len;
						end
					end
				end
				ST_CIPHER: begin
					if (pos_q == CW'(1)) begin
						pos_q  <= len_q;
						half_q <= !half_q;
						if (half_q) begin
							round_q <= round_q + 2'd1;
							if (round_q == 2'd2) begin
								state_q <= ST_EMIT;
							end
						end
					end else begin
						pos_q <= pos_q - CW'(1);
					end
				end
				ST_EMIT: begin
					if (pos_q == CW'(1)) begin
						state_q <= ST_LOAD;
						ovf_q   <= 1'b0;
						round_q <= '0;
					end else begin
						pos_q <= pos_q - CW'(1);
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		idx_s1         <= raddr;
		xc_s1.pos      <= pos_q;
		xc_s1.backward <= backward;
		xc_s1.decode   <= dec_q;
		xc_s1.first    <= (pos_q == len_q);
		fwd_s1         <= we && (waddr == raddr);
		fwdd_s1        <= wdata;
		last_s1        <= (pos_q == CW'(1));
		ovf_s1         <= ovf_q;
	end

	assign strobe          = emit_s1;
	assign result.out_byte = data_s1;
	assign result.out_last = last_s1;
	assign result.overflow = ovf_s1;

	// A result word only follows a read issued by the output sweep.
	a_strobe_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(state_q == ST_EMIT))
		else $error("result word without an output read");

	// The read stage carries either a transform step or an output byte, never both.
	a_stage_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(val_s1 && emit_s1))
		else $error("transform and output collide in the read stage");

	// The position count stays within the packet while the passes run.
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CIPHER) |-> ((pos_q != '0) && (pos_q <= len_q)))
		else $error("position count out of range");

	// The fill count never passes the buffer capacity.
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= MAX_CNT)
		else $error("buffer fill count beyond capacity");

	// The final byte of a packet closes its run of result words.
	a_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && result.out_last) |=> !strobe)
		else $error("result word after the final byte");

endmodule

`default_nettype wire

### sim/byte_chain_packet_cipher_core_test.sv
// Self-checking testbench for the byte chain packet cipher core.
`timescale 1ns / 1ps

// Packets are pushed into the core word by word over the start/busy handshake.
// Every accepted input word goes to a scoreboard, which holds its own copy of the
// packet buffer. When a word marked last is accepted, the scoreboard runs the
// three cipher rounds in the configured direction and queues one expected result
// word per stored byte. Each strobed result is checked field by field against the
// oldest queued word. The run steps through phases with different sender idling
// and both cipher directions, and it drains the core before each direction write so
// that the direction register is only written while the core is idle.
module byte_chain_packet_cipher_core_test;

	localparam int CAPACITY    = bcpc_pkg::MAX_PACKET_DEF;
	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE      = 8;

	// The scoreboard mirrors the buffer, the byte count, the overflow flag and the
	// direction register, and it keeps the result words that are still due.
	class cipher_checker;
		bcpc_pkg::out_word_t due[$];
		logic [7:0] held[CAPACITY];
		int         held_count;
		bit         dropped;
		bit         decode;
		int         mismatches;
		int         results_seen;
		int         packets;
		int         overflowed;
		int         decoded;
		int         words_in;

		function new();
			held_count   = 0;
			dropped      = 1'b0;
			decode       = 1'b0;
			mismatches   = 0;
			results_seen = 0;
			packets      = 0;
			overflowed   = 0;
			decoded      = 0;
			words_in     = 0;
		endfunction

		static function logic [7:0] spin_left(logic [7:0] v, int n);
			int s;
			s = n & 7;
			return (v << s) | (v >> (8 - s));
		endfunction

		static function logic [7:0] spin_right(logic [7:0] v, int n);
			int s;
			s = n & 7;
			return (v >> s) | (v << (8 - s));
		endfunction

		// Three rounds over the first len bytes of the held buffer. Encoding runs a
		// forward pass then a backward pass per round; decoding undoes them in the
		// opposite order. The position count runs from len down to 1.
		function void cipher_packet(int len);
			logic [7:0] a;
			logic [7:0] chain;
			logic [7:0] keep;
			logic [7:0] p;
			int         idx;
			for (int r = 0; r < 3; r++) begin
				if (!decode) begin
					chain = 8'h00;
					for (int pos = len; pos > 0; pos--) begin
						idx = len - pos;
						p = pos[7:0];
						a = spin_left(held[idx], 3);
						a = a + p;
						a = a ^ chain;
						chain = a;
						a = spin_right(a, pos);
						a = ~a;
						a = a + bcpc_pkg::ADD_KEY;
						held[idx] = a;
					end
					chain = 8'h00;
					for (int pos = len; pos > 0; pos--) begin
						idx = pos - 1;
						p = pos[7:0];
						a = spin_left(held[idx], 4);
						a = a + p;
						a = a ^ chain;
						chain = a;
						a = a ^ bcpc_pkg::XOR_KEY;
						a = spin_right(a, 3);
						held[idx] = a;
					end
				end else begin
					chain = 8'h00;
					for (int pos = len; pos > 0; pos--) begin
						idx = pos - 1;
						p = pos[7:0];
						a = spin_left(held[idx], 3);
						a = a ^ bcpc_pkg::XOR_KEY;
						keep = a;
						a = a ^ chain;
						a = a - p;
						a = spin_right(a, 4);
						chain = keep;
						held[idx] = a;
					end
					chain = 8'h00;
					for (int pos = len; pos > 0; pos--) begin
						idx = len - pos;
						p = pos[7:0];
						a = held[idx] - bcpc_pkg::ADD_KEY;
						a = ~a;
						a = spin_left(a, pos);
						keep = a;
						a = a ^ chain;
						a = a - p;
						a = spin_right(a, 3);
						chain = keep;
						held[idx] = a;
					end
				end
			end
		endfunction

		function void note_word(bcpc_pkg::in_word_t w);
			bcpc_pkg::out_word_t o;
			words_in++;
			if (held_count < CAPACITY) begin
				held[held_count] = w.data_byte;
				held_count++;
			end else begin
				dropped = 1'b1;
			end
			if (w.last) begin
				cipher_packet(held_count);
				for (int k = 0; k < held_count; k++) begin
					o.out_byte = held[k];
					o.out_last = (k == held_count - 1);
					o.overflow = dropped;
					due.push_back(o);
				end
				packets++;
				if (dropped)
					overflowed++;
				if (decode)
					decoded++;
				held_count = 0;
				dropped    = 1'b0;
			end
		endfunction

		task report_mismatch(string what);
			mismatches++;
			$display("[%0t] mismatch: %s", $realtime, what);
		endtask

		task check_word(bcpc_pkg::out_word_t r);
			bcpc_pkg::out_word_t e;
			results_seen++;
			if (due.size() == 0) begin
				report_mismatch($sformatf("unexpected result byte %02h", r.out_byte));
			end else begin
				e = due.pop_front();
				if (r.out_byte !== e.out_byte)
					report_mismatch($sformatf("out_byte %02h, want %02h", r.out_byte,
						e.out_byte));
				if (r.out_last !== e.out_last)
					report_mismatch($sformatf("out_last %b, want %b", r.out_last, e.out_last));
				if (r.overflow !== e.overflow)
					report_mismatch($sformatf("overflow %b, want %b", r.overflow, e.overflow));
			end
		endtask

		function int pending();
			return due.size();
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	bcpc_pkg::in_word_t  item;
	logic                strobe;
	bcpc_pkg::out_word_t result;
	logic                direction_we;
	logic                direction_wdata;

	cipher_checker sb;
	int            idle_pct;
	int            cycles = 0;

	byte_chain_packet_cipher_core i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.item            (item),
		.strobe          (strobe),
		.result          (result),
		.direction_we    (direction_we),
		.direction_wdata (direction_wdata)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Watchdog. A correct run ends far below this limit.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout with %0d result words still due", sb.pending());
			$display("FAIL");
			$finish;
		end
	end

	// Both the accepted input words and the strobed results are sampled at the
	// rising edge, before the core's own registers update.
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				sb.note_word(item);
			if (strobe)
				sb.check_word(result);
		end
	end

	// Offers one word. The sender may sit idle first, at random, and start is left high
	// after acceptance so that back-to-back words follow without a gap.
	task automatic send_word(input logic [7:0] b, input logic l);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			start = 1'b0;
			item  = bcpc_pkg::in_word_t'($urandom);
			@(negedge clk);
		end
		start          = 1'b1;
		item.data_byte = b;
		item.last      = l;
		do
			@(posedge clk);
		while (busy);
	endtask

	task automatic send_packet(input int len);
		for (int i = 0; i < len; i++)
			send_word(8'($urandom_range(255)), i == len - 1);
	endtask

	// Holds the sender off until every due result is out, then lets the core settle.
	task automatic drain();
		@(negedge clk);
		start = 1'b0;
		while (sb.pending() > 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	// The direction register is only written with the core idle.
	task automatic set_direction(input bit d);
		drain();
		direction_we    = 1'b1;
		direction_wdata = d;
		sb.decode       = d;
		@(negedge clk);
		direction_we    = 1'b0;
	endtask

	// Random packets, mostly short, with the odd mid-sized, full or overflowing one.
	task automatic random_packets(input int word_budget);
		int sent;
		int len;
		int pick;
		sent = 0;
		while (sent < word_budget) begin
			pick = $urandom_range(15);
			if (pick == 0)
				len = $urandom_range(CAPACITY, CAPACITY + 4);
			else if (pick == 1)
				len = $urandom_range(9, CAPACITY - 1);
			else
				len = $urandom_range(1, 8);
			send_packet(len);
			sent += len;
		end
	endtask

	initial begin
		sb              = new();
		idle_pct        = 0;
		arst_n          = 1'b0;
		start           = 1'b0;
		item            = '0;
		direction_we    = 1'b0;
		direction_wdata = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// Directed part: single-byte packets at the byte extremes, short packets,
		// both directions, a packet of exactly full capacity comes later.
		set_direction(1'b0);
		send_word(8'h00, 1'b1);
		send_word(8'hFF, 1'b1);
		send_word(8'h80, 1'b0);
		send_word(8'h01, 1'b1);
		send_word(8'hA5, 1'b0);
		send_word(8'h5A, 1'b0);
		send_word(8'h00, 1'b0);
		send_word(8'hFF, 1'b1);
		set_direction(1'b1);
		send_word(8'h00, 1'b1);
		send_word(8'hFF, 1'b1);
		send_word(8'h7F, 1'b0);
		send_word(8'hFE, 1'b1);
		send_word(8'h3C, 1'b0);
		send_word(8'hC3, 1'b0);
		send_word(8'h01, 1'b1);

		// No idling, decode. Starts with a packet that overflows and whose last
		// word is itself one of the dropped bytes.
		send_packet(CAPACITY + 2);
		random_packets(16);

		// Heavy sender idling, encode, starting with a packet of exactly capacity.
		idle_pct = 88;
		set_direction(1'b0);
		send_packet(CAPACITY);
		random_packets(12);

		// Light idling, decode.
		idle_pct = 19;
		set_direction(1'b1);
		random_packets(12);

		// No idling again, encode.
		idle_pct = 0;
		set_direction(1'b0);
		random_packets(12);

		drain();

		$display("covered %0d input words in %0d packets, %0d decoded, %0d overflowed",
			sb.words_in, sb.packets, sb.decoded, sb.overflowed);
		$display("checked %0d result words, %0d mismatches", sb.results_seen,
			sb.mismatches);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

### files.f
hdl/bcpc_pkg.sv
hdl/bcpc_mem.sv
hdl/bcpc_xform.sv
hdl/byte_chain_packet_cipher_core.sv
sim/byte_chain_packet_cipher_core_test.sv
